### hw/rtl/coordinate_fifo_with_search_top_macros.svh
// ----------------------------------------------------------------------------
// Coordinate FIFO assertion macros
// Clocked, reset-qualified property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_FIFO_WITH_SEARCH_TOP_MACROS_SVH
`define COORDINATE_FIFO_WITH_SEARCH_TOP_MACROS_SVH

// same-cycle implication
`define CFS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cfs_pkg.sv
// ----------------------------------------------------------------------------
// Coordinate FIFO package
// Shared widths, operation codes and engine state encoding.
// ----------------------------------------------------------------------------
package cfs_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int COORD_BITS_DEF  = 16;

    localparam int FIELD_BITS   = 16;  // width of coordinate fields on the ports
    localparam int KIND_BITS    = 2;
    localparam int IN_DATA_BITS = 2 * FIELD_BITS;

    // command queue between front and engine; power of two
    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_CHECK = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_SCAN = 3'b100
    } eng_state_t;

endpackage

### hw/rtl/cfs_front.sv
// ----------------------------------------------------------------------------
// Coordinate FIFO front end
// Accepts input transfers, decodes the operation and buffers commands.
// ----------------------------------------------------------------------------
module cfs_front #(
    parameter int COORD_BITS = cfs_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cfs_pkg::IN_DATA_BITS-1:0]  s_tdata,
    input  logic [cfs_pkg::KIND_BITS-1:0]     s_tuser,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output cfs_pkg::kind_t                    cmd_op,
    output logic [COORD_BITS-1:0]             cmd_x,
    output logic [COORD_BITS-1:0]             cmd_y
);

    localparam int PW = $clog2(cfs_pkg::CMDQ_DEPTH);
    localparam int CW = PW + 1;

    cfs_pkg::kind_t        op_q [cfs_pkg::CMDQ_DEPTH];
    logic [COORD_BITS-1:0] x_q  [cfs_pkg::CMDQ_DEPTH];
    logic [COORD_BITS-1:0] y_q  [cfs_pkg::CMDQ_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          push, pop;

    assign s_tready  = (cnt_reg != CW'(cfs_pkg::CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    assign cmd_op = op_q[rd_ptr_reg];
    assign cmd_x  = x_q[rd_ptr_reg];
    assign cmd_y  = y_q[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // coordinates keep only the low COORD_BITS bits (zero-extended if wider)
    always_ff @(posedge aclk) begin
        if (push) begin
            op_q[wr_ptr_reg] <= cfs_pkg::kind_t'(s_tuser);
            x_q[wr_ptr_reg]  <= COORD_BITS'(s_tdata[cfs_pkg::FIELD_BITS-1:0]);
            y_q[wr_ptr_reg]  <= COORD_BITS'(s_tdata[cfs_pkg::IN_DATA_BITS-1:cfs_pkg::FIELD_BITS]);
        end
    end

endmodule

### hw/rtl/cfs_engine.sv
// ----------------------------------------------------------------------------
// Coordinate FIFO engine
// Ring buffer storage, operation sequencer, serial search and result register.
// ----------------------------------------------------------------------------
module cfs_engine #(
    parameter int QUEUE_DEPTH = cfs_pkg::QUEUE_DEPTH_DEF,
    parameter int COORD_BITS  = cfs_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  cfs_pkg::kind_t                  cmd_op,
    input  logic [COORD_BITS-1:0]           cmd_x,
    input  logic [COORD_BITS-1:0]           cmd_y,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic                            res_ok,
    output logic [cfs_pkg::FIELD_BITS-1:0]  res_x,
    output logic [cfs_pkg::FIELD_BITS-1:0]  res_y
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = 2 * COORD_BITS;

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
        return (idx == IW'(QUEUE_DEPTH - 1)) ? '0 : idx + IW'(1);
    endfunction

    logic [EW-1:0] mem [QUEUE_DEPTH];

    cfs_pkg::eng_state_t state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [OW-1:0] occ_reg, occ_next;
    logic [OW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic [COORD_BITS-1:0] key_x_reg, key_x_next;
    logic [COORD_BITS-1:0] key_y_reg, key_y_next;
    logic [EW-1:0] rd_data_reg;

    logic          out_free, take;
    logic          wr_en, rd_en;
    logic [IW-1:0] rd_addr;
    logic          match;
    logic          ld, ld_ok;
    logic [cfs_pkg::FIELD_BITS-1:0] ld_x, ld_y;

    logic                           valid_reg;
    logic                           ok_reg;
    logic [cfs_pkg::FIELD_BITS-1:0] x_reg, y_reg;

    assign out_free  = !valid_reg || res_ready;
    assign cmd_ready = (state_reg == cfs_pkg::S_IDLE) && out_free;
    assign take      = cmd_valid && cmd_ready;
    assign match     = (rd_data_reg == {key_y_reg, key_x_reg});

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        occ_next   = occ_reg;
        cnt_next   = cnt_reg;
        scan_next  = scan_reg;
        key_x_next = key_x_reg;
        key_y_next = key_y_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = scan_reg;
        ld         = 1'b0;
        ld_ok      = 1'b0;
        ld_x       = '0;
        ld_y       = '0;
        unique case (state_reg)
            cfs_pkg::S_IDLE: begin
                if (take) begin
                    unique case (cmd_op)
                        cfs_pkg::KIND_PUSH: begin
                            ld = 1'b1;
                            if (occ_reg != OW'(QUEUE_DEPTH)) begin
                                wr_en     = 1'b1;
                                tail_next = ring_next(tail_reg);
                                occ_next  = occ_reg + OW'(1);
                                ld_ok     = 1'b1;
                            end
                        end
                        cfs_pkg::KIND_POP: begin
                            if (occ_reg != '0) begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                head_next  = ring_next(head_reg);
                                occ_next   = occ_reg - OW'(1);
                                state_next = cfs_pkg::S_POP;
                            end else begin
                                ld = 1'b1;
                            end
                        end
                        cfs_pkg::KIND_CHECK: begin
                            if (occ_reg != '0) begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                scan_next  = ring_next(head_reg);
                                cnt_next   = occ_reg;
                                key_x_next = cmd_x;
                                key_y_next = cmd_y;
                                state_next = cfs_pkg::S_SCAN;
                            end else begin
                                ld = 1'b1;
                            end
                        end
                        cfs_pkg::KIND_CLEAR: begin
                            ld        = 1'b1;
                            ld_ok     = (occ_reg != '0);
                            head_next = '0;
                            tail_next = '0;
                            occ_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            cfs_pkg::S_POP: begin
                ld         = 1'b1;
                ld_ok      = 1'b1;
                ld_x       = cfs_pkg::FIELD_BITS'(rd_data_reg[COORD_BITS-1:0]);
                ld_y       = cfs_pkg::FIELD_BITS'(rd_data_reg[EW-1:COORD_BITS]);
                state_next = cfs_pkg::S_IDLE;
            end
            cfs_pkg::S_SCAN: begin
                // rd_data_reg holds the entry read last cycle; the next read is issued here unless the scan ends
                if (match || cnt_reg == OW'(1)) begin
                    ld         = 1'b1;
                    ld_ok      = match;
                    state_next = cfs_pkg::S_IDLE;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg;
                    scan_next = ring_next(scan_reg);
                    cnt_next  = cnt_reg - OW'(1);
                end
            end
            default: state_next = cfs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cfs_pkg::S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            if (ld) begin
                valid_reg <= 1'b1;
            end else if (res_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        scan_reg  <= scan_next;
        key_x_reg <= key_x_next;
        key_y_reg <= key_y_next;
        if (ld) begin
            ok_reg <= ld_ok;
            x_reg  <= ld_x;
            y_reg  <= ld_y;
        end
    end

    // entry store: one write port at the tail, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[tail_reg] <= {cmd_y, cmd_x};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign res_valid = valid_reg;
    assign res_ok    = ok_reg;
    assign res_x     = x_reg;
    assign res_y     = y_reg;

endmodule

### hw/rtl/coordinate_fifo_with_search_top.sv
// Response: push, clear, and pop/check on an empty queue load the result register as
//   the engine takes the command; a pop goes through the entry read register and S_POP;
//   a check scans in S_SCAN, one stored entry per cycle through the single read port,
//   until a match or the last entry. Push/clear: 1 item per cycle while m_tready is high.
// Reset (aresetn low, synchronous): head, tail and occupancy to zero, command
//   queue and result register empty; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// Coordinate FIFO with membership search
// Ring-buffer queue of (x, y) coordinates with push, pop, check and clear.
// ----------------------------------------------------------------------------
module coordinate_fifo_with_search_top #(
    parameter int QUEUE_DEPTH = cfs_pkg::QUEUE_DEPTH_DEF,
    parameter int COORD_BITS  = cfs_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cfs_pkg::IN_DATA_BITS-1:0]  s_tdata,  // [15:0] coord_x, [31:16] coord_y
    input  logic [cfs_pkg::KIND_BITS-1:0]     s_tuser,  // [1:0] kind
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cfs_pkg::IN_DATA_BITS-1:0]  m_tdata,  // [15:0] removed_x, [31:16] removed_y
    output logic [0:0]                        m_tuser   // [0] ok
);

    // front -> engine command transfer
    logic                  cmd_valid;
    logic                  cmd_ready;
    cfs_pkg::kind_t        cmd_op;
    logic [COORD_BITS-1:0] cmd_x;
    logic [COORD_BITS-1:0] cmd_y;

    logic                           res_ok;
    logic [cfs_pkg::FIELD_BITS-1:0] res_x;
    logic [cfs_pkg::FIELD_BITS-1:0] res_y;

    // Front: takes transfers while its short command queue has room, so new
    // items keep arriving during a long search.
    cfs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_op    (cmd_op),
        .cmd_x     (cmd_x),
        .cmd_y     (cmd_y)
    );

    // Engine: owns the ring buffer, runs one command at a time and keeps the
    // finished result in its output register until the sink takes it.
    cfs_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_op    (cmd_op),
        .cmd_x     (cmd_x),
        .cmd_y     (cmd_y),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_ok    (res_ok),
        .res_x     (res_x),
        .res_y     (res_y)
    );

    // removed coordinate is zero for everything but a successful pop
    assign m_tdata = {res_y, res_x};
    assign m_tuser = res_ok;

endmodule

### hw/rtl/cfs_checker.sv
// ----------------------------------------------------------------------------
// Coordinate FIFO port checker
// Watches the stream ports for ordering and result-format slips.
// ----------------------------------------------------------------------------
`include "coordinate_fifo_with_search_top_macros.svh"

module cfs_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [cfs_pkg::IN_DATA_BITS-1:0]  s_tdata,
    input logic [cfs_pkg::KIND_BITS-1:0]     s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [cfs_pkg::IN_DATA_BITS-1:0]  m_tdata,
    input logic [0:0]                        m_tuser
);

    localparam logic [2:0] QFULL = 3'(cfs_pkg::CMDQ_DEPTH);

    // items accepted but not yet answered
    logic [2:0] pend_reg;
    logic       s_xfer, m_xfer, s_stall, m_stall, m_fail;
    logic [cfs_pkg::IN_DATA_BITS+cfs_pkg::KIND_BITS-1:0] s_word;
    logic [cfs_pkg::IN_DATA_BITS:0]                      m_word;

    assign s_xfer  = s_tvalid && s_tready;
    assign m_xfer  = m_tvalid && m_tready;
    assign s_stall = s_tvalid && !s_tready;
    assign m_stall = m_tvalid && !m_tready;
    assign m_fail  = m_tvalid && !m_tuser[0];
    assign s_word  = {s_tuser, s_tdata};
    assign m_word  = {m_tuser, m_tdata};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + 3'(s_xfer) - 3'(m_xfer);
        end
    end

    `CFS_ASSERT_NEXT(a_in_hold, s_stall, s_tvalid && $stable(s_word), "stalled input moved")
    `CFS_ASSERT_NEXT(a_out_hold, m_stall, m_tvalid && $stable(m_word), "stalled result moved")
    `CFS_ASSERT_SAME(a_no_orphan, m_tvalid, pend_reg != 3'd0, "result without an accepted item")
    `CFS_ASSERT_SAME(a_fail_zero, m_fail, m_tdata == '0, "failed result carries a coordinate")
    `CFS_ASSERT_SAME(a_ready_full, !s_tready, pend_reg >= QFULL, "input stalled with room left")

endmodule

bind coordinate_fifo_with_search_top cfs_checker u_cfs_checker (.*);

### sim/tb.sv
// ----------------------------------------------------------------------------
// Coordinate FIFO testbench
// Drives push, pop, check and clear commands into the coordinate queue with
// random gaps and result back-pressure. Every result is scored against a
// ring-buffer model of the queue kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
    import cfs_pkg::*;

    // Queue geometry, kept the same as the DUT instance
    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int CBITS = COORD_BITS_DEF;
    localparam logic [FIELD_BITS-1:0] CMASK = (CBITS >= FIELD_BITS) ? {FIELD_BITS{1'b1}}
        : ({FIELD_BITS{1'b1}} >> (FIELD_BITS - CBITS));

    // Watchdog: a check scans at most DEPTH entries and the stall on each side is bounded
    // by pick_gap, so a quiet stretch that reaches STALL_LIMIT means a hang.
    localparam int STALL_LIMIT = 3000;
    // Drain time after the last result: longer than one full scan
    localparam int TAIL_CYCLES = 2 * DEPTH + 40;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic                  ok;
        logic [FIELD_BITS-1:0] rx;
        logic [FIELD_BITS-1:0] ry;
    } qresult_t;

    // Kind mixes for the random phases
    typedef enum int {
        MIX_BALANCED,
        MIX_FILL,
        MIX_DRAIN,
        MIX_SEARCH
    } traffic_mix_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_BITS-1:0] s_tdata;   // [15:0] coord_x, [31:16] coord_y
    logic [KIND_BITS-1:0]    s_tuser;   // [1:0] kind
    logic                    m_tvalid;
    logic                    m_tready;
    logic [IN_DATA_BITS-1:0] m_tdata;   // [15:0] removed_x, [31:16] removed_y
    logic [0:0]              m_tuser;   // [0] ok

    coordinate_fifo_with_search_top #(
        .QUEUE_DEPTH(DEPTH),
        .COORD_BITS (CBITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // ------------------------------------------------------------------
    // Queue model state: ring of stored coordinates plus indices
    // ------------------------------------------------------------------
    logic [FIELD_BITS-1:0] ring_x [DEPTH];
    logic [FIELD_BITS-1:0] ring_y [DEPTH];
    int unsigned head_q;
    int unsigned tail_q;
    int unsigned fill_q;

    // results the DUT still owes, oldest first
    qresult_t pending_results [$];
    qresult_t oldest_owed;

    // run statistics
    int errors;
    int n_push, n_pop, n_check, n_clear;
    int n_results;
    int n_full_refused, n_empty_pop, n_check_hits, peak_fill;

    // idle control shared by the sender and the result stall process
    bit idle_on;
    int stall_left;
    int quiet_cycles;

    // ------------------------------------------------------------------
    // Clock: 20 time unit period
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Gap length: mostly short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 40);
    endfunction

    // Coordinate: small grid values so checks hit, extremes, or full range
    function automatic logic [FIELD_BITS-1:0] pick_coord();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 3))
            0: return FIELD_BITS'($urandom_range(0, 15));
            1: return raw[0] ? {FIELD_BITS{1'b1}} : {FIELD_BITS{1'b0}};
            default: return raw[FIELD_BITS-1:0];
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Queue model: applies one command, returns the result it owes
    // ------------------------------------------------------------------
    task automatic apply_queue_op(input kind_t op, input logic [FIELD_BITS-1:0] cx_in,
                                  input logic [FIELD_BITS-1:0] cy_in, output qresult_t res);
        logic [FIELD_BITS-1:0] cx;
        logic [FIELD_BITS-1:0] cy;
        int unsigned idx;
        int unsigned n;
        cx  = cx_in & CMASK;
        cy  = cy_in & CMASK;
        res = '0;
        case (op)
            KIND_PUSH: begin
                if (fill_q < DEPTH) begin
                    ring_x[tail_q] = cx;
                    ring_y[tail_q] = cy;
                    tail_q = (tail_q + 1) % DEPTH;
                    fill_q++;
                    res.ok = 1'b1;
                    if (fill_q > peak_fill) peak_fill = fill_q;
                end else begin
                    n_full_refused++;
                end
            end
            KIND_POP: begin
                if (fill_q != 0) begin
                    res.ok = 1'b1;
                    res.rx = ring_x[head_q];
                    res.ry = ring_y[head_q];
                    head_q = (head_q + 1) % DEPTH;
                    fill_q--;
                end else begin
                    n_empty_pop++;
                end
            end
            KIND_CHECK: begin
                // linear scan from the head over the occupied slots only
                idx = head_q;
                for (n = 0; n < fill_q && !res.ok; n++) begin
                    if (ring_x[idx] == cx && ring_y[idx] == cy)
                        res.ok = 1'b1;
                    idx = (idx + 1) % DEPTH;
                end
                if (res.ok) n_check_hits++;
            end
            default: begin
                res.ok = (fill_q != 0);
                head_q = 0;
                tail_q = 0;
                fill_q = 0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender: one command transfer, with an optional gap in front
    // ------------------------------------------------------------------
    task automatic send_op(input kind_t op, input logic [FIELD_BITS-1:0] cx,
                           input logic [FIELD_BITS-1:0] cy);
        int gap;
        qresult_t res;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {cy, cx};
        // transfer completes at the first rising edge with tready high
        do @(posedge aclk); while (s_tready !== 1'b1);
        apply_queue_op(op, cx, cy, res);
        pending_results.push_back(res);
        case (op)
            KIND_PUSH:  n_push++;
            KIND_POP:   n_pop++;
            KIND_CHECK: n_check++;
            default:    n_clear++;
        endcase
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side back-pressure: random stalls, off when idle_on is clear
    // ------------------------------------------------------------------
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: each result transfer against the oldest owed result
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input logic [32:0] want,
                                 input logic [32:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h actual %h", $time, what, want, got);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", 33'h0, {m_tuser, m_tdata});
            end else begin
                oldest_owed = pending_results.pop_front();
                if (m_tuser[0] !== oldest_owed.ok)
                    note_mismatch("ok", 33'(oldest_owed.ok), 33'(m_tuser[0]));
                if (m_tdata[FIELD_BITS-1:0] !== oldest_owed.rx)
                    note_mismatch("removed_x", 33'(oldest_owed.rx),
                                  33'(m_tdata[FIELD_BITS-1:0]));
                if (m_tdata[2*FIELD_BITS-1:FIELD_BITS] !== oldest_owed.ry)
                    note_mismatch("removed_y", 33'(oldest_owed.ry),
                                  33'(m_tdata[2*FIELD_BITS-1:FIELD_BITS]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too many cycles without any transfer ends the run
    // ------------------------------------------------------------------
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: watchdog expired, %0d results still owed", $time,
                 pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Pop, check and clear on an empty queue all report 0
    task automatic test_empty_queue();
        idle_on = 1'b0;
        send_op(KIND_POP,   16'h0000, 16'h0000);
        send_op(KIND_CHECK, 16'h0000, 16'h0000);
        send_op(KIND_CLEAR, 16'h0000, 16'h0000);
        send_op(KIND_CHECK, 16'hFFFF, 16'hFFFF);
    endtask

    // Field extremes, hits and near misses, pop order, clear on a non-empty queue
    task automatic test_basic_ops();
        idle_on = 1'b1;
        send_op(KIND_PUSH,  16'h0000, 16'h0000);
        send_op(KIND_PUSH,  16'hFFFF, 16'hFFFF);
        send_op(KIND_PUSH,  16'h0000, 16'hFFFF);
        send_op(KIND_PUSH,  16'hFFFF, 16'h0000);
        send_op(KIND_PUSH,  16'h1234, 16'hABCD);
        send_op(KIND_CHECK, 16'hFFFF, 16'hFFFF);
        send_op(KIND_CHECK, 16'hFFFF, 16'hFFFE);   // one bit off
        send_op(KIND_CHECK, 16'h0000, 16'hFFFF);
        send_op(KIND_CHECK, 16'hABCD, 16'h1234);   // x and y swapped
        send_op(KIND_POP,   16'h5A5A, 16'hA5A5);   // coordinate ignored on pop
        send_op(KIND_CHECK, 16'h0000, 16'h0000);   // popped, so gone
        send_op(KIND_POP,   16'h0000, 16'h0000);
        send_op(KIND_CLEAR, 16'hFFFF, 16'hFFFF);   // non-empty clear
        send_op(KIND_POP,   16'h0000, 16'h0000);
        send_op(KIND_CHECK, 16'h1234, 16'hABCD);
        send_op(KIND_PUSH,  16'h5555, 16'hAAAA);
        send_op(KIND_PUSH,  16'hAAAA, 16'h5555);
        send_op(KIND_POP,   16'h0000, 16'h0000);
        send_op(KIND_POP,   16'h0000, 16'h0000);
    endtask

    function automatic kind_t pick_kind(input traffic_mix_t mix);
        int r;
        int push_top;
        int pop_top;
        r = $urandom_range(0, 99);
        if (r < 2) return KIND_CLEAR;
        case (mix)
            MIX_FILL:   begin push_top = 75; pop_top = 85; end
            MIX_DRAIN:  begin push_top = 15; pop_top = 75; end
            MIX_SEARCH: begin push_top = 25; pop_top = 40; end
            default:    begin push_top = 36; pop_top = 68; end
        endcase
        if (r < push_top) return KIND_PUSH;
        if (r < pop_top)  return KIND_POP;
        return KIND_CHECK;
    endfunction

    // Phases of random length and mix: fill phases run into the full queue,
    // drain phases into the empty one, and the ring indices wrap many times.
    task automatic test_random_traffic(input int n_items);
        int sent;
        int phase_len;
        traffic_mix_t mix;
        kind_t op;
        logic [FIELD_BITS-1:0] cx;
        logic [FIELD_BITS-1:0] cy;
        int unsigned slot;
        sent = 0;
        while (sent < n_items) begin
            phase_len = $urandom_range(20, 120);
            if (phase_len > n_items - sent) phase_len = n_items - sent;
            mix       = traffic_mix_t'($urandom_range(0, 3));
            idle_on   = ($urandom_range(0, 3) != 0);
            repeat (phase_len) begin
                op = pick_kind(mix);
                cx = pick_coord();
                cy = pick_coord();
                // half the checks look for a coordinate that is stored somewhere
                if (op == KIND_CHECK && fill_q != 0 && $urandom_range(0, 1) == 1) begin
                    slot = (head_q + $urandom_range(0, fill_q - 1)) % DEPTH;
                    cx   = ring_x[slot];
                    cy   = ring_y[slot];
                end
                send_op(op, cx, cy);
                sent++;
            end
        end
    endtask

    // Sender holds off until every owed result is back, then resumes
    task automatic test_drain_pause();
        idle_on = 1'b1;
        send_op(KIND_PUSH, pick_coord(), pick_coord());
        send_op(KIND_CHECK, pick_coord(), pick_coord());
        release_input();
        wait_for_results();
        send_op(KIND_POP, 16'h0000, 16'h0000);
        send_op(KIND_CHECK, pick_coord(), pick_coord());
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_PUSH;
        idle_on  = 1'b0;
        head_q   = 0;
        tail_q   = 0;
        fill_q   = 0;
        errors   = 0;
        n_push = 0; n_pop = 0; n_check = 0; n_clear = 0;
        n_results = 0;
        n_full_refused = 0; n_empty_pop = 0; n_check_hits = 0; peak_fill = 0;

        // single reset at the start of the run
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_queue();
        test_basic_ops();
        test_random_traffic(950);
        test_drain_pause();
        test_random_traffic(950);

        // let the queue drain, then watch a while for stray results
        release_input();
        idle_on = 1'b0;
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end

        $display("Covered %0d commands: push %0d, pop %0d, check %0d, clear %0d; %0d results",
                 n_push + n_pop + n_check + n_clear, n_push, n_pop, n_check, n_clear,
                 n_results);
        $display("Full-queue pushes %0d, empty pops %0d, check hits %0d, peak fill %0d of %0d",
                 n_full_refused, n_empty_pop, n_check_hits, peak_fill, DEPTH);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
